FILE: design/ntcfan_pkg.sv
`default_nettype none

package ntcfan_pkg;

	localparam int SAMPLE_W = 12;
	localparam int MILLI_W = 16;
	localparam int DEG_W = 6;
	localparam int SETPOINT_W = 6;
	localparam int HYST_W = 4;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 6;
	localparam int BUILTIN_ENTRIES = 51;
	localparam int QUEUE_DEPTH = 2;
	localparam int DIV_STEPS = MILLI_W;
	localparam int HALF_DEGREE = 500;

	localparam logic [SAMPLE_W-1:0] NTC_CURVE [BUILTIN_ENTRIES] = '{
		12'd939, 12'd978, 12'd1017, 12'd1058, 12'd1098, 12'd1140, 12'd1182, 12'd1225,
		12'd1269, 12'd1313, 12'd1357, 12'd1402, 12'd1448, 12'd1493, 12'd1539, 12'd1585,
		12'd1632, 12'd1678, 12'd1725, 12'd1771, 12'd1818, 12'd1864, 12'd1910, 12'd1956,
		12'd2002, 12'd2048, 12'd2093, 12'd2138, 12'd2183, 12'd2227, 12'd2271, 12'd2314,
		12'd2357, 12'd2399, 12'd2441, 12'd2482, 12'd2522, 12'd2562, 12'd2601, 12'd2639,
		12'd2677, 12'd2714, 12'd2750, 12'd2786, 12'd2821, 12'd2855, 12'd2888, 12'd2921,
		12'd2953, 12'd2984, 12'd3014
	};

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SETPOINT   = 2'd0,
		REG_HYSTERESIS = 2'd1,
		REG_POWER_ON   = 2'd2,
		REG_FAN_AUTO   = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FAN_HOLD = 2'd0,
		FAN_LOW  = 2'd1,
		FAN_HIGH = 2'd2
	} fan_cmd_t;

	typedef enum logic [1:0] {
		KIND_ZERO,
		KIND_SAT,
		KIND_INTERP
	} kind_t;

	typedef struct packed {
		logic [SETPOINT_W-1:0] setpoint;
		logic [HYST_W-1:0]     hysteresis;
		logic                  power_on;
		logic                  fan_auto;
	} cfg_t;

	typedef struct packed {
		kind_t               kind;
		logic [DEG_W-1:0]    base;
		logic [SAMPLE_W-1:0] num;
		logic [SAMPLE_W-1:0] den;
	} item_t;

	function automatic logic [SAMPLE_W-1:0] ntc_curve(input logic [DEG_W-1:0] idx);
		logic [SAMPLE_W-1:0] val;
		val = '0;
		if (idx < DEG_W'(BUILTIN_ENTRIES)) begin
			val = NTC_CURVE[idx];
		end
		return val;
	endfunction

endpackage

`default_nettype wire

FILE: design/ntcfan_front.sv
`default_nettype none

module ntcfan_front import ntcfan_pkg::*; #(
	parameter int TABLE_ENTRIES = 51
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [SAMPLE_W-1:0] adc_sample,
	input  wire logic                q_full,
	output logic                     q_push,
	output item_t                    q_item
);

	localparam int USED = (TABLE_ENTRIES < BUILTIN_ENTRIES) ? TABLE_ENTRIES : BUILTIN_ENTRIES;
	localparam int KW = $clog2(USED + 1);
	localparam logic [KW-1:0] USED_K = KW'(USED);

	typedef enum logic [1:0] {
		F_IDLE,
		F_SEARCH,
		F_PUSH
	} fstate_t;

	fstate_t             state_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [KW-1:0]       k_q;
	item_t               item_q;

	logic                above;
	logic [KW-1:0]       k_prev;
	logic [SAMPLE_W-1:0] curve_k;
	logic [SAMPLE_W-1:0] curve_prev;

	assign k_prev = k_q - KW'(1);
	assign curve_k = ntc_curve(DEG_W'(k_q));
	assign curve_prev = ntc_curve(DEG_W'(k_prev));
	assign above = (k_q < USED_K) && (sample_q > curve_k);

	assign in_stall = (state_q != F_IDLE);
	assign q_push = (state_q == F_PUSH) && !q_full;
	assign q_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						state_q <= F_SEARCH;
					end
				end
				F_SEARCH: begin
					if (!above) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (in_valid) begin
					sample_q <= adc_sample;
					k_q <= '0;
				end
			end
			F_SEARCH: begin
				if (above) begin
					k_q <= k_q + KW'(1);
				end else begin
					item_q.base <= DEG_W'(k_prev);
					item_q.num <= sample_q - curve_prev;
					item_q.den <= curve_k - curve_prev;
					if (k_q == '0) begin
						item_q.kind <= KIND_ZERO;
					end else if (k_q >= USED_K) begin
						item_q.kind <= KIND_SAT;
					end else begin
						item_q.kind <= KIND_INTERP;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: design/ntcfan_queue.sv
`default_nettype none

module ntcfan_queue import ntcfan_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output logic       empty,
	output item_t      pop_item
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t         mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push && !full, pop && !empty})
				2'b10: count_q <= count_q + CW'(1);
				2'b01: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

FILE: design/ntcfan_back.sv
`default_nettype none

module ntcfan_back import ntcfan_pkg::*; #(
	parameter int TABLE_ENTRIES = 51,
	parameter int STEADY_BAND = 800
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic               q_empty,
	input  wire item_t              q_item,
	output logic                    q_pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [MILLI_W-1:0]      temp_milli,
	output logic [DEG_W-1:0]        shown_degrees,
	output logic                    shown_changed,
	output logic [1:0]              fan_command
);

	localparam int USED = (TABLE_ENTRIES < BUILTIN_ENTRIES) ? TABLE_ENTRIES : BUILTIN_ENTRIES;
	localparam logic [MILLI_W-1:0] SAT_MILLI = MILLI_W'((USED - 1) * 1000);
	localparam logic [DEG_W-1:0] SAT_DEG = DEG_W'(USED - 1);
	localparam logic [MILLI_W-1:0] BAND = MILLI_W'(STEADY_BAND);
	localparam int SW = $clog2(DIV_STEPS);
	localparam int PRODW = SAMPLE_W + 10;
	localparam int RW = SAMPLE_W + 1;

	typedef enum logic [2:0] {
		B_IDLE,
		B_LOAD,
		B_DIV,
		B_FINISH,
		B_UPDATE
	} bstate_t;

	bstate_t              state_q;
	item_t                item_q;
	logic [MILLI_W-1:0]   dividend_q;
	logic [MILLI_W-1:0]   quo_q;
	logic [RW-1:0]        rem_q;
	logic [SW-1:0]        step_q;
	logic [MILLI_W-1:0]   base_milli_q;
	logic [MILLI_W-1:0]   milli_q;
	logic [DEG_W-1:0]     deg_q;

	logic [MILLI_W-1:0]   ref_q;
	logic [DEG_W-1:0]     last_deg_q;
	logic                 first_q;
	logic [DEG_W-1:0]     room_q;

	logic                 out_valid_q;
	logic [MILLI_W-1:0]   milli_out_q;
	logic [DEG_W-1:0]     shown_q;
	logic                 changed_q;
	fan_cmd_t             fan_q;

	logic [PRODW-1:0]     num_prod;
	logic [PRODW-1:0]     base_prod;
	logic [RW-1:0]        trial;
	logic                 fits;
	logic [MILLI_W-1:0]   diff;
	logic                 refresh;
	logic [DEG_W-1:0]     room_next;
	logic [DEG_W:0]       room_low;
	logic [DEG_W:0]       sp_high;
	fan_cmd_t             fan_next;
	logic                 out_free;

	assign num_prod = PRODW'(item_q.num) * PRODW'(1000);
	assign base_prod = PRODW'(item_q.base) * PRODW'(1000);
	assign trial = {rem_q[RW-2:0], dividend_q[MILLI_W-1]};
	assign fits = (trial >= RW'(item_q.den));

	assign diff = (milli_q > ref_q) ? (milli_q - ref_q) : (ref_q - milli_q);
	assign refresh = (diff > BAND) || first_q;
	assign room_next = refresh ? deg_q : room_q;
	assign room_low = (DEG_W + 1)'(room_next) + (DEG_W + 1)'(cfg.hysteresis);
	assign sp_high = (DEG_W + 1)'(cfg.setpoint) + (DEG_W + 1)'(cfg.hysteresis);

	always_comb begin
		fan_next = FAN_HOLD;
		if (cfg.power_on && cfg.fan_auto) begin
			if (room_low < (DEG_W + 1)'(cfg.setpoint)) begin
				fan_next = FAN_LOW;
			end else if ((DEG_W + 1)'(room_next) > sp_high) begin
				fan_next = FAN_HIGH;
			end
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign q_pop = (state_q == B_IDLE) && !q_empty;

	assign out_valid = out_valid_q;
	assign temp_milli = milli_out_q;
	assign shown_degrees = shown_q;
	assign shown_changed = changed_q;
	assign fan_command = fan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
			ref_q <= MILLI_W'(27000);
			first_q <= 1'b1;
			room_q <= DEG_W'(25);
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						state_q <= B_LOAD;
					end
				end
				B_LOAD: begin
					state_q <= (item_q.kind == KIND_INTERP) ? B_DIV : B_FINISH;
				end
				B_DIV: begin
					if (step_q == SW'(DIV_STEPS - 1)) begin
						state_q <= B_FINISH;
					end
				end
				B_FINISH: begin
					state_q <= B_UPDATE;
				end
				B_UPDATE: begin
					if (out_free) begin
						state_q <= B_IDLE;
						out_valid_q <= 1'b1;
						if (refresh) begin
							if (first_q || (deg_q != last_deg_q)) begin
								ref_q <= milli_q;
							end
							first_q <= 1'b0;
							room_q <= deg_q;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					item_q <= q_item;
				end
			end
			B_LOAD: begin
				dividend_q <= num_prod[MILLI_W-1:0];
				base_milli_q <= base_prod[MILLI_W-1:0];
				rem_q <= '0;
				quo_q <= '0;
				step_q <= '0;
			end
			B_DIV: begin
				dividend_q <= {dividend_q[MILLI_W-2:0], 1'b0};
				rem_q <= fits ? (trial - RW'(item_q.den)) : trial;
				quo_q <= {quo_q[MILLI_W-2:0], fits};
				step_q <= step_q + SW'(1);
			end
			B_FINISH: begin
				case (item_q.kind)
					KIND_ZERO: begin
						milli_q <= '0;
						deg_q <= '0;
					end
					KIND_SAT: begin
						milli_q <= SAT_MILLI;
						deg_q <= SAT_DEG;
					end
					default: begin
						milli_q <= base_milli_q + quo_q;
						deg_q <= item_q.base + DEG_W'(quo_q >= MILLI_W'(HALF_DEGREE));
					end
				endcase
			end
			B_UPDATE: begin
				if (out_free) begin
					if (refresh) begin
						last_deg_q <= deg_q;
					end
					milli_out_q <= milli_q;
					shown_q <= room_next;
					changed_q <= refresh;
					fan_q <= fan_next;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: design/ntc_temperature_fan_control.sv
// channel   direction  handshake              payload
// in        in         in_valid / in_stall    adc_sample
// out       out        out_valid / out_stall  temp_milli, shown_degrees, shown_changed, fan_command
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// front end walks the ntc table one entry a cycle
// back end: load, a 16-step serial divider, finish and update per item; a clamped sample skips the divider
// a two-entry queue between them lets the back end finish one item while the next is searched
// a finished result sits in the output register while the back end takes the next item
// reset sets control state, the config registers and the steadying state to defaults; no clearing pass
`default_nettype none

module ntc_temperature_fan_control import ntcfan_pkg::*; #(
	parameter int TABLE_ENTRIES = 51,
	parameter int STEADY_BAND = 800
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [SAMPLE_W-1:0]    adc_sample,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [MILLI_W-1:0]          temp_milli,
	output logic [DEG_W-1:0]            shown_degrees,
	output logic                        shown_changed,
	output logic [1:0]                  fan_command,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t  cfg_q;
	item_t push_item;
	item_t pop_item;
	logic  q_push;
	logic  q_full;
	logic  q_pop;
	logic  q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint <= SETPOINT_W'(27);
			cfg_q.hysteresis <= HYST_W'(1);
			cfg_q.power_on <= 1'b0;
			cfg_q.fan_auto <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_SETPOINT:   cfg_q.setpoint <= cfg_data[SETPOINT_W-1:0];
				REG_HYSTERESIS: cfg_q.hysteresis <= cfg_data[HYST_W-1:0];
				REG_POWER_ON:   cfg_q.power_on <= cfg_data[0];
				REG_FAN_AUTO:   cfg_q.fan_auto <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	ntcfan_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.adc_sample (adc_sample),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (push_item)
	);

	ntcfan_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_item  (pop_item)
	);

	ntcfan_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.STEADY_BAND(STEADY_BAND)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (q_empty),
		.q_item        (pop_item),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.temp_milli    (temp_milli),
		.shown_degrees (shown_degrees),
		.shown_changed (shown_changed),
		.fan_command   (fan_command)
	);

endmodule

`default_nettype wire

FILE: tb/ntc_reading_checker.sv
`timescale 1ns / 100ps

module ntc_reading_checker import ntcfan_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic                   in_stall,
	input  wire logic [SAMPLE_W-1:0]    adc_sample,
	input  wire logic                   out_valid,
	input  wire logic                   out_stall,
	input  wire logic [MILLI_W-1:0]     temp_milli,
	input  wire logic [DEG_W-1:0]       shown_degrees,
	input  wire logic                   shown_changed,
	input  wire logic [1:0]             fan_command,
	input  wire logic                   cfg_valid,
	input  wire logic                   cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output int                          mismatches,
	output int                          pending,
	output int                          checked,
	output int                          refreshes,
	output int                          fan_low_seen,
	output int                          fan_high_seen,
	output int                          clamped,
	output int                          saturated
);

	localparam int STEADY_BAND = 800;
	localparam int LAST_DEGREE = 50;
	localparam int REPORT_LIMIT = 30;

	// divider reading at each whole degree from 0 upward
	localparam int unsigned THERMISTOR_TABLE [LAST_DEGREE+1] = '{
		939, 978, 1017, 1058, 1098, 1140, 1182, 1225, 1269,
		1313, 1357, 1402, 1448, 1493, 1539, 1585, 1632, 1678, 1725, 1771, 1818,
		1864, 1910, 1956, 2002, 2048, 2093, 2138, 2183, 2227, 2271, 2314, 2357,
		2399, 2441, 2482, 2522, 2562, 2601, 2639, 2677, 2714, 2750, 2786, 2821,
		2855, 2888, 2921, 2953, 2984, 3014
	};

	typedef struct packed {
		logic [MILLI_W-1:0] milli;
		logic [DEG_W-1:0]   degrees;
		logic               changed;
		fan_cmd_t           fan;
	} reading_t;

	reading_t readings_due [$];

	logic [SETPOINT_W-1:0] setpoint;
	logic [HYST_W-1:0]     hysteresis;
	logic                  power_on;
	logic                  fan_auto;
	int unsigned           anchor_milli;
	logic [DEG_W-1:0]      last_rounded;
	logic                  first_sample;
	logic [DEG_W-1:0]      room_degrees;

	initial begin
		mismatches = 0;
		pending = 0;
		checked = 0;
		refreshes = 0;
		fan_low_seen = 0;
		fan_high_seen = 0;
		clamped = 0;
		saturated = 0;
	end

	function automatic int unsigned sample_to_milli(input logic [SAMPLE_W-1:0] s);
		int k;
		int unsigned lo;
		int unsigned hi;
		k = 0;
		while (k <= LAST_DEGREE && s > THERMISTOR_TABLE[k])
			k++;
		if (k == 0)
			return 0;
		if (k > LAST_DEGREE)
			return LAST_DEGREE * 1000;
		lo = THERMISTOR_TABLE[k-1];
		hi = THERMISTOR_TABLE[k];
		return (k - 1) * 1000 + (1000 * (s - lo)) / (hi - lo);
	endfunction

	task automatic predict_reading(input logic [SAMPLE_W-1:0] s, output reading_t r);
		int unsigned milli;
		int unsigned drift;
		logic [DEG_W-1:0] rounded;
		int room;
		int lower;
		int upper;
		milli = sample_to_milli(s);
		drift = milli > anchor_milli ? milli - anchor_milli : anchor_milli - milli;
		r.milli = MILLI_W'(milli);
		r.changed = 1'b0;
		r.fan = FAN_HOLD;
		if (milli == 0)
			clamped++;
		if (milli == LAST_DEGREE * 1000)
			saturated++;
		if (drift > STEADY_BAND || first_sample) begin
			rounded = DEG_W'((milli + HALF_DEGREE) / 1000);
			// re-anchor on the first sample or when the rounded degree moves
			if (first_sample || rounded != last_rounded)
				anchor_milli = milli;
			first_sample = 1'b0;
			last_rounded = rounded;
			room_degrees = rounded;
			r.changed = 1'b1;
			refreshes++;
		end
		if (power_on && fan_auto) begin
			room = int'(room_degrees);
			lower = int'(setpoint) - int'(hysteresis);
			upper = int'(setpoint) + int'(hysteresis);
			if (room < lower)
				r.fan = FAN_LOW;
			else if (room > upper)
				r.fan = FAN_HIGH;
		end
		if (r.fan == FAN_LOW)
			fan_low_seen++;
		if (r.fan == FAN_HIGH)
			fan_high_seen++;
		r.degrees = room_degrees;
	endtask

	task automatic check_field(input string field, input logic [MILLI_W-1:0] want,
			input logic [MILLI_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t %s expected %0d got %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reading_t due;
		reading_t fresh;
		if (!arst_n) begin
			readings_due.delete();
			setpoint = 6'd27;
			hysteresis = 4'd1;
			power_on = 1'b0;
			fan_auto = 1'b0;
			anchor_milli = 27000;
			last_rounded = '0;
			first_sample = 1'b1;
			room_degrees = 6'd25;
		end else begin
			if (out_valid && !out_stall) begin
				if (readings_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t result transfer with no reading due: temp_milli %0d",
							$time, temp_milli);
				end else begin
					due = readings_due.pop_front();
					checked++;
					check_field("temp_milli", due.milli, temp_milli);
					check_field("shown_degrees", due.degrees, shown_degrees);
					check_field("shown_changed", due.changed, shown_changed);
					check_field("fan_command", due.fan, fan_command);
				end
			end
			if (in_valid && !in_stall) begin
				predict_reading(adc_sample, fresh);
				readings_due.push_back(fresh);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_SETPOINT: setpoint = cfg_data[SETPOINT_W-1:0];
					REG_HYSTERESIS: hysteresis = cfg_data[HYST_W-1:0];
					REG_POWER_ON: power_on = cfg_data[0];
					REG_FAN_AUTO: fan_auto = cfg_data[0];
					default: ;
				endcase
			end
		end
		pending = readings_due.size();
	end

endmodule

FILE: tb/ntc_temperature_fan_control_test.sv
`timescale 1ns / 100ps

module ntc_temperature_fan_control_test;
	import ntcfan_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int PHASES = 12;
	localparam int PHASE_SAMPLES = 100;
	localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [SAMPLE_W-1:0] adc_sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [MILLI_W-1:0] temp_milli;
	logic [DEG_W-1:0] shown_degrees;
	logic shown_changed;
	logic [1:0] fan_command;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_SETPOINT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int mismatches;
	int pending;
	int checked;
	int refreshes;
	int fan_low_seen;
	int fan_high_seen;
	int clamped;
	int saturated;

	int stall_odds = 0;
	int gap_odds = 0;
	bit hold_go = 1'b0;
	int sent = 0;
	int quiet_cycles = 0;

	ntc_temperature_fan_control DUT (.*);

	ntc_reading_checker reading_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t no transfer for %0d cycles", $time, quiet_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver: random stall bursts, or one long hold-off on request
	initial begin : receiver
		int burst;
		forever begin
			@(negedge clk);
			if (hold_go) begin
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
				hold_go = 1'b0;
			end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				burst = $urandom_range(1, 19);
				out_stall <= 1'b1;
				repeat (burst) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		int gap;
		@(negedge clk);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		adc_sample <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// half slow drift around the steadying band, the rest jumps across and off the table
	function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] prev);
		int roll;
		int v;
		roll = $urandom_range(0, 9);
		if (roll < 5) begin
			v = int'(prev) + int'($urandom_range(0, 40)) - 20;
			if (v < 0)
				v = 0;
			else if (v > SAMPLE_MAX)
				v = SAMPLE_MAX;
		end else if (roll < 8) begin
			v = $urandom_range(900, 3050);
		end else begin
			v = $urandom_range(0, SAMPLE_MAX);
		end
		return SAMPLE_W'(v);
	endfunction

	initial begin : stimulus
		logic [SAMPLE_W-1:0] opening [18] = '{
			12'd0, 12'd939, 12'd940, 12'd978, 12'd4095, 12'd3014, 12'd3015,
			12'd0, 12'd2116, 12'd2153, 12'd2155, 12'hAAA, 12'h555, 12'd1500,
			12'd2700, 12'd2271, 12'd1017, 12'd2984
		};
		logic [SAMPLE_W-1:0] s;
		int p;
		int n;
		int sp;
		int hy;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// first sample after reset with the fan logic still off
		send_sample(12'd2048);
		send_sample(12'd2060);
		drain();
		write_reg(REG_POWER_ON, 6'd1);
		write_reg(REG_FAN_AUTO, 6'd1);
		foreach (opening[i])
			send_sample(opening[i]);
		s = 12'd2048;

		for (p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: begin
					sp = 16;
					hy = 0;
				end
				1: begin
					sp = 35;
					hy = 15;
				end
				2: begin
					sp = 0;
					hy = 15;
				end
				3: begin
					sp = 63;
					hy = 0;
				end
				default: begin
					sp = $urandom_range(0, 63);
					hy = $urandom_range(0, 15);
				end
			endcase
			write_reg(REG_SETPOINT, CFG_DATA_W'(sp));
			write_reg(REG_HYSTERESIS, {2'($urandom), 4'(hy)});
			write_reg(REG_POWER_ON, {5'($urandom), 1'(p != 4)});
			write_reg(REG_FAN_AUTO, {5'($urandom), 1'(p != 5)});
			if (p >= PHASES - 2) begin
				stall_odds = 0;
				gap_odds = 0;
			end else begin
				stall_odds = 1 << $urandom_range(1, 4);
				gap_odds = 1 << $urandom_range(1, 4);
			end
			if (p == 6)
				hold_go = 1'b1;
			for (n = 0; n < PHASE_SAMPLES; n++) begin
				s = pick_sample(s);
				send_sample(s);
			end
		end
		drain();
		repeat (100) @(posedge clk);

		$display("%0d samples sent, %0d readings checked, %0d display refreshes",
			sent, checked, refreshes);
		$display("zero-clamped %0d, saturated %0d, fan low %0d, fan high %0d",
			clamped, saturated, fan_low_seen, fan_high_seen);
		if (mismatches == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d readings never arrived", mismatches, pending);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
